### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Codes and control types shared by the sorted queue cells and top level.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

endpackage

### design/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded min-priority queue held as a sorted shift chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is offered with start high; it is taken at a rising edge
// where start is high and busy is low. in_mode selects enqueue of
// in_item_value with in_item_priority, or dequeue of the head entry.
// Every transaction yields exactly one result, shown on the out_ ports for
// one cycle with out_valid high, in the cycle right after acceptance.
// The receiver cannot stall; it must take the result in that cycle.
// Throughput is one transaction per cycle: every cell compares its stored
// priority with the new one in parallel and shifts in one step, so busy
// stays low. Equal priorities leave in arrival order because a new entry
// is placed behind every entry with lower or equal priority.
// An enqueue into a full queue is dropped with status full; a dequeue from
// an empty queue changes nothing and reports status empty.
// Reset (synchronous, rst_n low) empties the queue: all cell valid bits,
// the entry count and the result strobe are cleared.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue import ssq_pkg::*; #(
  parameter int CAPACITY      = 16,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 16,
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [VALUE_BITS-1:0]    in_item_value,
  input  logic [PRIORITY_BITS-1:0] in_item_priority,
  output logic                     out_valid,
  output logic [VALUE_BITS-1:0]    out_head_value,
  output logic [PRIORITY_BITS-1:0] out_head_priority,
  output logic [COUNT_BITS-1:0]    out_entry_count,
  output logic                     out_is_empty,
  output logic [1:0]               out_status
);

  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

  logic                  accept;
  logic                  is_full;
  logic                  is_none;
  cell_cmd_t             cmd;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r;

  // Per-cell outputs, each read at a fixed place by its neighbors.
  logic                     cell_le    [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic [VALUE_BITS-1:0]    cell_value [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];

  // Every cell updates in parallel, so a transaction is never held off.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_full = (count_r == FULL_COUNT);
  assign is_none = (count_r == '0);

  always_comb begin
    cmd.enq    = accept && (in_mode == MODE_ENQ) && !is_full;
    cmd.deq    = accept && (in_mode == MODE_DEQ) && !is_none;
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    if (cmd.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.deq) begin
      count_nxt = count_r - 1'b1;
    end
    if (in_mode == MODE_ENQ && is_full) begin
      status_nxt = STAT_FULL;
    end else if (in_mode == MODE_DEQ && is_none) begin
      status_nxt = STAT_EMPTY;
    end
  end

  // Chain of cells; cell 0 is the head. Cell 0 sees a virtual left neighbor
  // that ranks ahead of everything, the last cell an empty right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_le;
    logic                     l_valid;
    logic [VALUE_BITS-1:0]    l_value;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic                     r_valid;
    logic [VALUE_BITS-1:0]    r_value;
    logic [PRIORITY_BITS-1:0] r_prio;

    if (i == 0) begin : g_first
      assign l_le    = 1'b1;
      assign l_valid = 1'b0;
      assign l_value = '0;
      assign l_prio  = '0;
    end else begin : g_mid_l
      assign l_le    = cell_le[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_mid_r
      assign r_valid = cell_valid[i+1];
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    ssq_cell #(
      .VALUE_BITS   (VALUE_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cmd),
      .new_value     (in_item_value),
      .new_priority  (in_item_priority),
      .left_le       (l_le),
      .left_valid    (l_valid),
      .left_value    (l_value),
      .left_priority (l_prio),
      .right_valid   (r_valid),
      .right_value   (r_value),
      .right_priority(r_prio),
      .le            (cell_le[i]),
      .valid         (cell_valid[i]),
      .value         (cell_value[i]),
      .priority_o    (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
      if (accept) begin
        status_r <= status_nxt;
      end
    end
  end

  // The cells hold the post-transaction state during the result cycle.
  assign out_valid         = out_valid_r;
  assign out_head_value    = cell_valid[0] ? cell_value[0] : '0;
  assign out_head_priority = cell_valid[0] ? cell_prio[0] : '0;
  assign out_entry_count   = count_r;
  assign out_is_empty      = is_none;
  assign out_status        = status_r;

endmodule

### design/ssq_cell.sv
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: keeps, inserts, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ssq_cell import ssq_pkg::*; #(
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic [VALUE_BITS-1:0]    new_value,
  input  logic [PRIORITY_BITS-1:0] new_priority,
  input  logic                     left_le,
  input  logic                     left_valid,
  input  logic [VALUE_BITS-1:0]    left_value,
  input  logic [PRIORITY_BITS-1:0] left_priority,
  input  logic                     right_valid,
  input  logic [VALUE_BITS-1:0]    right_value,
  input  logic [PRIORITY_BITS-1:0] right_priority,
  output logic                     le,
  output logic                     valid,
  output logic [VALUE_BITS-1:0]    value,
  output logic [PRIORITY_BITS-1:0] priority_o
);

  logic                     valid_r, valid_nxt;
  logic [VALUE_BITS-1:0]    value_r, value_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // Entries are sorted, so le is true on a prefix of the chain.
  assign le = valid_r && (prio_r <= new_priority);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.enq && !le) begin
      if (left_le) begin
        valid_nxt = 1'b1;
        value_nxt = new_value;
        prio_nxt  = new_priority;
      end else begin
        valid_nxt = left_valid;
        value_nxt = left_value;
        prio_nxt  = left_priority;
      end
    end else if (cmd.deq) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
      prio_nxt  = right_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign valid      = valid_r;
  assign value      = value_r;
  assign priority_o = prio_r;

endmodule

### design/ssq_checker.sv
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssq_checker import ssq_pkg::*; #(
  parameter int CAPACITY      = 16,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 16,
  parameter int COUNT_BITS    = $clog2(CAPACITY + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [VALUE_BITS-1:0]    out_head_value,
  input logic [PRIORITY_BITS-1:0] out_head_priority,
  input logic [COUNT_BITS-1:0]    out_entry_count,
  input logic                     out_is_empty,
  input logic [1:0]               out_status
);

  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

  logic taken;
  logic res_empty;
  logic head_clear;
  logic res_full;
  logic res_none;

  assign taken      = start && !busy;
  assign res_empty  = out_valid && out_is_empty;
  assign head_clear = (out_entry_count == '0) && (out_head_value == '0) &&
                      (out_head_priority == '0);
  assign res_full   = out_valid && (out_status == STAT_FULL);
  assign res_none   = out_valid && (out_status == STAT_EMPTY);

  // Exactly one result per accepted transaction, in the next cycle.
  `ASSERT_NEXT(a_result_follows, taken, out_valid, "missing result")
  `ASSERT_NEXT(a_no_spurious, !taken, !out_valid, "result without transaction")

  // Empty flag and head fields agree with the count.
  `ASSERT_IMPL(a_empty_head, res_empty, head_clear, "empty result has stale head")

  // A dropped enqueue only happens on a full queue, a failed dequeue on an empty one.
  `ASSERT_IMPL(a_full_status, res_full, out_entry_count == FULL_COUNT, "full with room left")
  `ASSERT_IMPL(a_empty_status, res_none, out_is_empty, "empty status on non-empty queue")

endmodule

bind stable_sorted_priority_queue ssq_checker #(
  .CAPACITY     (CAPACITY),
  .VALUE_BITS   (VALUE_BITS),
  .PRIORITY_BITS(PRIORITY_BITS),
  .COUNT_BITS   (COUNT_BITS)
) u_ssq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_head_value   (out_head_value),
  .out_head_priority(out_head_priority),
  .out_entry_count  (out_entry_count),
  .out_is_empty     (out_is_empty),
  .out_status       (out_status)
);

### bench/tb_stable_sorted_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue
// Self-checking bench for the sorted min-priority queue. Transactions are
// offered at the falling edge and taken at the rising edge when busy is
// low. A behavioral copy of the queue predicts the head, count, empty flag
// and status of every result. A checker compares each strobed result with
// the oldest prediction. Directed tests cover the corner cases, and a long
// random run sweeps the occupancy between empty and full.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;
  import ssq_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int VALUE_BITS    = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

  // One predicted result: the state of the queue head after a transaction.
  typedef struct {
    logic [VALUE_BITS-1:0]    head_value;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     is_empty;
    status_t                  status;
  } queue_head_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_mode;
  logic [VALUE_BITS-1:0]    in_item_value;
  logic [PRIORITY_BITS-1:0] in_item_priority;
  logic                     out_valid;
  logic [VALUE_BITS-1:0]    out_head_value;
  logic [PRIORITY_BITS-1:0] out_head_priority;
  logic [COUNT_BITS-1:0]    out_entry_count;
  logic                     out_is_empty;
  logic [1:0]               out_status;

  // Behavioral copy of the queue: slot 0 holds the head, entries are kept in
  // ascending priority with ties in arrival order.
  logic [VALUE_BITS-1:0]    model_value [CAPACITY];
  logic [PRIORITY_BITS-1:0] model_priority [CAPACITY];
  int                       model_count;

  // Heads predicted for accepted transactions, oldest first.
  queue_head_t pending_heads[$];

  // Run statistics for the closing summary.
  int n_enqueues;
  int n_dequeues;
  int n_full_drops;
  int n_empty_dequeues;
  int n_results;
  int n_mismatches;
  int peak_count;

  stable_sorted_priority_queue #(
    .CAPACITY     (CAPACITY),
    .VALUE_BITS   (VALUE_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_head_value   (out_head_value),
    .out_head_priority(out_head_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  // 50 MHz clock: 10 ns high, 10 ns low.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one transaction to the behavioral queue and returns the head that
  // the block must report for it. An enqueue walks past every entry whose
  // priority is lower or equal, which is what keeps equal priorities FIFO.
  function automatic queue_head_t predict_queue_step(input logic mode,
                                                     input logic [VALUE_BITS-1:0] value,
                                                     input logic [PRIORITY_BITS-1:0] prio);
    queue_head_t head;
    int          pos;
    int          i;
    head.status = STAT_OK;
    if (mode == MODE_ENQ) begin
      if (model_count >= CAPACITY) begin
        head.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < model_count && model_priority[pos] <= prio) pos++;
        for (i = model_count; i > pos; i--) begin
          model_value[i]    = model_value[i-1];
          model_priority[i] = model_priority[i-1];
        end
        model_value[pos]    = value;
        model_priority[pos] = prio;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        head.status = STAT_EMPTY;
      end else begin
        for (i = 0; i + 1 < model_count; i++) begin
          model_value[i]    = model_value[i+1];
          model_priority[i] = model_priority[i+1];
        end
        model_count--;
      end
    end
    // An empty queue reports zero for both head fields.
    head.is_empty      = (model_count == 0);
    head.head_value    = head.is_empty ? '0 : model_value[0];
    head.head_priority = head.is_empty ? '0 : model_priority[0];
    head.entry_count   = COUNT_BITS'(model_count);
    return head;
  endfunction

  // Offers one transaction at the falling edge and holds it until the block
  // takes it. The prediction is queued at the accepting edge. Start is left
  // high so that back-to-back transactions need no extra assignment.
  task automatic send_item(input logic mode,
                           input logic [VALUE_BITS-1:0] value,
                           input logic [PRIORITY_BITS-1:0] prio);
    queue_head_t head;
    @(negedge clk);
    start            <= 1'b1;
    in_mode          <= mode;
    in_item_value    <= value;
    in_item_priority <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    head = predict_queue_step(mode, value, prio);
    pending_heads.push_back(head);
    if (mode == MODE_ENQ) n_enqueues++;
    else n_dequeues++;
    if (head.status == STAT_FULL) n_full_drops++;
    if (head.status == STAT_EMPTY) n_empty_dequeues++;
    if (model_count > peak_count) peak_count = model_count;
  endtask

  // Drops start for a burst of idle cycles.
  task automatic idle_gap(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Counts a failure and prints the first few in detail.
  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      n_mismatches++;
      if (n_mismatches <= 10)
        $display("Mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    end
  endtask

  // Result checker. The receiver cannot stall, so every strobed result is
  // taken at the edge that ends its cycle and matched against the oldest
  // prediction. A result with nothing pending is a failure in itself.
  always @(posedge clk) begin : result_check
    queue_head_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_heads.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("Unexpected result at %0t: head value %0d, count %0d, status %0d",
                   $realtime, out_head_value, out_entry_count, out_status);
      end else begin
        want = pending_heads.pop_front();
        check_field("head_value", int'(want.head_value), int'(out_head_value));
        check_field("head_priority", int'(want.head_priority), int'(out_head_priority));
        check_field("entry_count", int'(want.entry_count), int'(out_entry_count));
        check_field("is_empty", int'(want.is_empty), int'(out_is_empty));
        check_field("status", int'(want.status), int'(out_status));
      end
    end
  end

  // A dequeue right after reset must report the empty status and no change.
  task automatic test_dequeue_empty();
    send_item(MODE_DEQ, 16'hFFFF, 16'hFFFF);
  endtask

  // Fills the queue with extreme values and several ties, then tries two
  // more enqueues, which must be dropped with the full status and leave the
  // contents unchanged.
  task automatic test_fill_and_overflow();
    logic [PRIORITY_BITS-1:0] fill_prio [CAPACITY];
    logic [VALUE_BITS-1:0]    fill_value [CAPACITY];
    int                       i;
    fill_prio  = '{16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h0000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h0002,
                   16'h0000, 16'hFFFE, 16'h8001, 16'h7FFF};
    fill_value = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                   16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000, 16'h0005, 16'h1234,
                   16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00};
    for (i = 0; i < CAPACITY; i++) send_item(MODE_ENQ, fill_value[i], fill_prio[i]);
    send_item(MODE_ENQ, 16'h0000, 16'h0000);
    send_item(MODE_ENQ, 16'hFFFF, 16'hFFFF);
  endtask

  // Pulls a few heads off the full queue; the tied zero priorities must come
  // out in the order they went in.
  task automatic test_drain_head();
    repeat (4) send_item(MODE_DEQ, 16'h0000, 16'h0000);
  endtask

  // Random traffic. The enqueue share is redrawn every 64 transactions so the
  // occupancy keeps swinging between empty and full, which exercises both
  // error statuses many times. Priorities are often drawn from a tiny range
  // to produce ties, and sometimes pinned to the extremes.
  task automatic test_random_traffic(input int n_items, input bit with_idle);
    int                       k;
    int                       enq_share;
    logic                     mode;
    logic [PRIORITY_BITS-1:0] prio;
    enq_share = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_share = 20;
          1: enq_share = 50;
          default: enq_share = 80;
        endcase
      end
      mode = ($urandom_range(0, 99) < enq_share) ? MODE_ENQ : MODE_DEQ;
      case ($urandom_range(0, 3))
        0: prio = PRIORITY_BITS'($urandom_range(0, 3));
        1: prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: prio = PRIORITY_BITS'($urandom);
      endcase
      send_item(mode, VALUE_BITS'($urandom), prio);
      // An idle burst follows about one item in four, leaving stretches of back-to-back traffic.
      if (with_idle && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 11));
    end
  endtask

  // Main sequence: reset once, directed tests, random traffic with idling,
  // then a closing stretch with start held high throughout.
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_mode          = MODE_ENQ;
    in_item_value    = '0;
    in_item_priority = '0;
    model_count      = 0;
    n_enqueues       = 0;
    n_dequeues       = 0;
    n_full_drops     = 0;
    n_empty_dequeues = 0;
    n_results        = 0;
    n_mismatches     = 0;
    peak_count       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_dequeue_empty();
    test_fill_and_overflow();
    test_drain_head();
    test_random_traffic(1700, 1'b1);
    test_random_traffic(300, 1'b0);

    @(negedge clk);
    start <= 1'b0;
    // Results come in the cycle after acceptance; wait them out, then keep
    // watching for any stray result.
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d results: %0d enqueues (%0d dropped as full), %0d dequeues (%0d empty).",
             n_results, n_enqueues, n_full_drops, n_dequeues, n_empty_dequeues);
    $display("Peak occupancy %0d of %0d entries; %0d mismatching fields.",
             peak_count, CAPACITY, n_mismatches);
    if (n_mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: ends the run as failed if it has not finished by this time.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### stable_sorted_priority_queue.f
+incdir+design
design/ssq_pkg.sv
design/ssq_cell.sv
design/stable_sorted_priority_queue.sv
design/ssq_checker.sv
bench/tb_stable_sorted_priority_queue.sv
